// ----- rtl/qhbd_pkg.sv -----
// shared types, constants and coefficient table for the quintic hermite basis block
package qhbd_pkg;

   localparam int IN_W              = 17;
   localparam int H_W               = 24;
   localparam int ACC_W             = 48;
   localparam int MAG_W             = 53;
   localparam int MUL_W             = MAG_W + H_W;
   localparam int DIV_W             = MAG_W + 16;
   localparam int VAL_W             = 32;
   localparam int NUM_FN            = 6;
   localparam int CNT_W             = 7;
   localparam int DEFAULT_FRAC_BITS = 16;

   localparam logic [IN_W-1:0]  T_ONE     = IN_W'(65536);
   localparam logic [H_W-1:0]   H_RESET   = H_W'(65536);
   localparam logic [MAG_W-1:0] MAG_CAP   = MAG_W'(1) << 52;
   localparam logic [1:0]       ORDER_LAST = 2'd3;
   localparam logic [2:0]       FN_LAST   = 3'd5;

   typedef struct packed {
      logic            last;
      logic [IN_W-1:0] t;
   } item_type;

   localparam logic signed [7:0] BASIS_HALVES [0:5][0:5] = '{
      '{ 8'sd2, 8'sd0, 8'sd0, -8'sd20,  8'sd30, -8'sd12 },
      '{ 8'sd0, 8'sd0, 8'sd0,  8'sd20, -8'sd30,  8'sd12 },
      '{ 8'sd0, 8'sd2, 8'sd0, -8'sd12,  8'sd16, -8'sd6  },
      '{ 8'sd0, 8'sd0, 8'sd0, -8'sd8,   8'sd14, -8'sd6  },
      '{ 8'sd0, 8'sd0, 8'sd1, -8'sd3,   8'sd3,  -8'sd1  },
      '{ 8'sd0, 8'sd0, 8'sd0,  8'sd1,  -8'sd2,   8'sd1  }
   };

   // j! / (j-d)! indexed by order d and power j
   localparam logic [6:0] FALL_FACT [0:3][0:5] = '{
      '{ 7'd1, 7'd1, 7'd1, 7'd1,  7'd1,  7'd1  },
      '{ 7'd0, 7'd1, 7'd2, 7'd3,  7'd4,  7'd5  },
      '{ 7'd0, 7'd0, 7'd2, 7'd6,  7'd12, 7'd20 },
      '{ 7'd0, 7'd0, 7'd0, 7'd6,  7'd24, 7'd60 }
   };

   localparam logic [1:0] SCALE_POW [0:5] = '{ 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2 };

   function automatic logic signed [ACC_W-1:0] coef_fn(input logic [2:0] f,
                                                      input logic [1:0] d,
                                                      input logic [2:0] k);
      logic [3:0]         j;
      logic signed [15:0] p;
      j = {1'b0, k} + {2'b00, d};
      if (j > 4'd5 || f > FN_LAST) begin
         return '0;
      end
      p = 16'(BASIS_HALVES[f][j[2:0]]) * signed'({9'b0, FALL_FACT[d][j[2:0]]});
      return ACC_W'(p) <<< 31;
   endfunction

endpackage

// ----- rtl/qhbd_front.sv -----
// input stage: accepts knots, clamps the parameter and holds one item for the queue
module qhbd_front import qhbd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [IN_W-1:0] req_t,
   input  logic            req_tlast,
   output logic            push_valid,
   input  logic            push_ready,
   output item_type        push_item
);

   logic     hold_valid_ff;
   item_type hold_item_ff;

   assign req_tready = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            hold_valid_ff <= req_tvalid;
         end
         if (req_tvalid && req_tready) begin
            hold_item_ff.t    <= (req_t > T_ONE) ? T_ONE : req_t;
            hold_item_ff.last <= req_tlast;
         end
      end
   end

endmodule

// ----- rtl/qhbd_queue.sv -----
// two-entry queue between the input stage and the evaluation engine
module qhbd_queue import qhbd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            mem_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff         <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

// ----- rtl/qhbd_engine.sv -----
// evaluation engine: horner, scaling by h and rounding over a shared serial multiplier and divider
module qhbd_engine import qhbd_pkg::*; #(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [H_W-1:0]          h_len,
   input  logic                    item_valid,
   input  item_type                item,
   output logic                    item_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [NUM_FN*VAL_W-1:0] rsp_tdata,
   output logic [2:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int SHIFT = 32 - FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_HMUL, S_HADD, S_POST, S_SMUL, S_SNEXT, S_SDIV, S_DNEXT,
      S_ROUND, S_EMIT
   } state_type;

   state_type               state_ff;
   logic [IN_W-1:0]         t_ff;
   logic                    last_ff;
   logic [1:0]              d_ff;
   logic [2:0]              f_ff;
   logic [2:0]              k_ff;
   logic [1:0]              scl_cnt_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    neg_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic [MUL_W-1:0]        mul_a_ff;
   logic [H_W-1:0]          mul_b_ff;
   logic [MUL_W-1:0]        prod_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [H_W-1:0]          rem_ff;
   logic [DIV_W-1:0]        num_ff;
   logic [DIV_W-1:0]        quo_ff;
   logic [VAL_W-1:0]        vals_ff [NUM_FN];
   logic                    rsp_valid_ff;
   logic [NUM_FN*VAL_W-1:0] rsp_data_ff;
   logic [2:0]              rsp_user_ff;
   logic                    rsp_last_ff;

   logic [H_W-1:0]          h_eff;
   logic signed [ACC_W-1:0] coef_top;
   logic signed [ACC_W-1:0] coef_cur;
   logic [ACC_W-1:0]        coef_top_abs;
   logic [MUL_W-16-1:0]     prod_q;
   logic signed [ACC_W-1:0] hsum;
   logic [ACC_W-1:0]        hsum_abs;
   logic [ACC_W-1:0]        acc_abs;
   logic [MAG_W-1:0]        scaled;
   logic [H_W:0]            trial;
   logic                    ge;
   logic [MAG_W-1:0]        qcap;
   logic [MAG_W:0]          rnd;
   logic [VAL_W-1:0]        sat_val;
   logic [1:0]              sp;
   logic                    emit_go;

   assign h_eff        = (h_len == '0) ? H_W'(1) : h_len;
   assign coef_top     = coef_fn(f_ff, d_ff, 3'd5 - {1'b0, d_ff});
   assign coef_cur     = coef_fn(f_ff, d_ff, k_ff);
   assign coef_top_abs = coef_top[ACC_W-1] ? ACC_W'(-coef_top) : ACC_W'(coef_top);
   assign prod_q       = prod_ff[MUL_W-1:16];
   assign hsum         = (neg_ff ? -signed'(prod_q[ACC_W-1:0]) : signed'(prod_q[ACC_W-1:0]))
                         + coef_cur;
   assign hsum_abs     = hsum[ACC_W-1] ? ACC_W'(-hsum) : ACC_W'(hsum);
   assign acc_abs      = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign scaled       = (prod_q > (MUL_W-16)'(MAG_CAP)) ? MAG_CAP : prod_q[MAG_W-1:0];
   assign trial        = {rem_ff, num_ff[DIV_W-1]};
   assign ge           = (trial >= {1'b0, h_eff});
   assign qcap         = (quo_ff > DIV_W'(MAG_CAP)) ? MAG_CAP : quo_ff[MAG_W-1:0];
   assign rnd          = ({1'b0, mag_ff} + ((MAG_W+1)'(1) << (SHIFT - 1))) >> SHIFT;
   assign sp           = SCALE_POW[f_ff];
   assign emit_go      = !rsp_valid_ff || rsp_tready;
   assign item_pop     = (state_ff == S_IDLE) && item_valid;

   always_comb begin
      if (neg_ff) begin
         sat_val = (rnd > (MAG_W+1)'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - rnd[31:0];
      end else begin
         sat_val = (rnd > (MAG_W+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         d_ff         <= '0;
         f_ff         <= '0;
      end else begin
         if (rsp_tready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  t_ff     <= item.t;
                  last_ff  <= item.last;
                  d_ff     <= '0;
                  f_ff     <= '0;
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               neg_ff   <= coef_top[ACC_W-1];
               mul_a_ff <= MUL_W'(coef_top_abs);
               mul_b_ff <= H_W'(t_ff);
               prod_ff  <= '0;
               cnt_ff   <= CNT_W'(H_W);
               k_ff     <= 3'd4 - {1'b0, d_ff};
               state_ff <= S_HMUL;
            end
            S_HMUL, S_SMUL: begin
               if (mul_b_ff[0]) begin
                  prod_ff <= prod_ff + mul_a_ff;
               end
               mul_a_ff <= mul_a_ff << 1;
               mul_b_ff <= mul_b_ff >> 1;
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= (state_ff == S_HMUL) ? S_HADD : S_SNEXT;
               end
            end
            S_HADD: begin
               acc_ff <= hsum;
               if (k_ff == 3'd0) begin
                  state_ff <= S_POST;
               end else begin
                  k_ff     <= k_ff - 3'd1;
                  neg_ff   <= hsum[ACC_W-1];
                  mul_a_ff <= MUL_W'(hsum_abs);
                  mul_b_ff <= H_W'(t_ff);
                  prod_ff  <= '0;
                  cnt_ff   <= CNT_W'(H_W);
                  state_ff <= S_HMUL;
               end
            end
            S_POST: begin
               neg_ff <= acc_ff[ACC_W-1];
               mag_ff <= MAG_W'(acc_abs);
               if (sp > d_ff) begin
                  scl_cnt_ff <= sp - d_ff;
                  mul_a_ff   <= MUL_W'(acc_abs);
                  mul_b_ff   <= h_eff;
                  prod_ff    <= '0;
                  cnt_ff     <= CNT_W'(H_W);
                  state_ff   <= S_SMUL;
               end else if (sp < d_ff) begin
                  scl_cnt_ff <= d_ff - sp;
                  num_ff     <= {MAG_W'(acc_abs), 16'b0};
                  rem_ff     <= '0;
                  quo_ff     <= '0;
                  cnt_ff     <= CNT_W'(DIV_W);
                  state_ff   <= S_SDIV;
               end else begin
                  state_ff <= S_ROUND;
               end
            end
            S_SNEXT: begin
               mag_ff <= scaled;
               if (scl_cnt_ff == 2'd1) begin
                  state_ff <= S_ROUND;
               end else begin
                  scl_cnt_ff <= scl_cnt_ff - 2'd1;
                  mul_a_ff   <= MUL_W'(scaled);
                  mul_b_ff   <= h_eff;
                  prod_ff    <= '0;
                  cnt_ff     <= CNT_W'(H_W);
                  state_ff   <= S_SMUL;
               end
            end
            S_SDIV: begin
               rem_ff   <= ge ? H_W'(trial - {1'b0, h_eff}) : trial[H_W-1:0];
               quo_ff   <= {quo_ff[DIV_W-2:0], ge};
               num_ff   <= num_ff << 1;
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_DNEXT;
               end
            end
            S_DNEXT: begin
               mag_ff <= qcap;
               if (scl_cnt_ff == 2'd1) begin
                  state_ff <= S_ROUND;
               end else begin
                  scl_cnt_ff <= scl_cnt_ff - 2'd1;
                  num_ff     <= {qcap, 16'b0};
                  rem_ff     <= '0;
                  quo_ff     <= '0;
                  cnt_ff     <= CNT_W'(DIV_W);
                  state_ff   <= S_SDIV;
               end
            end
            S_ROUND: begin
               vals_ff[f_ff] <= sat_val;
               if (f_ff == FN_LAST) begin
                  state_ff <= S_EMIT;
               end else begin
                  f_ff     <= f_ff + 3'd1;
                  state_ff <= S_INIT;
               end
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {vals_ff[5], vals_ff[4], vals_ff[3],
                                   vals_ff[2], vals_ff[1], vals_ff[0]};
                  rsp_user_ff  <= {last_ff, d_ff};
                  rsp_last_ff  <= (d_ff == ORDER_LAST);
                  f_ff         <= '0;
                  if (d_ff == ORDER_LAST) begin
                     d_ff     <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     d_ff     <= d_ff + 2'd1;
                     state_ff <= S_INIT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/quintic_hermite_basis_derivatives.sv -----
// top level of the quintic hermite basis and derivative evaluator
// each knot gives four result transactions; the engine finishes one knot before it takes the next
// knot rate is set by the shared serial multiplier and restoring divider
// synchronous active-high reset clears control state and sets the interval length to 1.0
module quintic_hermite_basis_derivatives import qhbd_pkg::*; #(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,   // knot_param
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [NUM_FN*VAL_W-1:0] rsp_tdata,   // val_h00, val_h10, val_h01, val_h11, val_h02, val_h12
   output logic [2:0]              rsp_tuser,   // deriv_order, end_of_table
   output logic                    rsp_tlast,
   input  logic                    csr_wr_en,
   input  logic [H_W-1:0]          csr_wr_data
);

   logic [H_W-1:0] h_len_ff;
   logic           push_valid;
   logic           push_ready;
   item_type       push_item;
   logic           pop_valid;
   logic           pop;
   item_type       pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_len_ff <= H_RESET;
      end else if (csr_wr_en) begin
         h_len_ff <= csr_wr_data;
      end
   end

   qhbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_t      (req_tdata[IN_W-1:0]),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   qhbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   qhbd_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .h_len      (h_len_ff),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_last_is_order3: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser[1:0] == ORDER_LAST)))
      else $error("tlast does not match final derivative order");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pop_only_when_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue popped while empty");
`endif

endmodule

// ----- bench/quintic_hermite_basis_derivatives_tb.sv -----
// self-checking bench for the quintic hermite basis and derivative evaluator
`timescale 1ns / 100ps

module quintic_hermite_basis_derivatives_tb;
   import qhbd_pkg::*;

   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam longint unsigned MAG_LIMIT = 64'd1 << 52;

   typedef struct {
      logic [1:0]  order;
      logic [31:0] val [0:5];
      logic        end_knot;
      logic        end_table;
   } basis_row_type;

   class basis_scoreboard;
      basis_row_type pending [$];
      int            errors;

      function longint scale_t(longint a, longint unsigned t);
         longint unsigned m;
         m = (a < 0) ? longint'(-a) : a;
         m = (m * t) >> 16;
         return (a < 0) ? -longint'(m) : longint'(m);
      endfunction

      function longint unsigned cap(longint unsigned v);
         return (v > MAG_LIMIT) ? MAG_LIMIT : v;
      endfunction

      function void note_knot(logic [16:0] t_in, logic last, logic [23:0] h_reg);
         longint unsigned t, h, m;
         longint c [0:5];
         longint acc;
         basis_row_type row;
         int n;
         bit neg;
         t = (t_in > 17'd65536) ? 65536 : t_in;
         h = (h_reg == 0) ? 1 : h_reg;
         for (int d = 0; d < 4; d++) begin
            row.order = d[1:0];
            for (int f = 0; f < 6; f++) begin
               for (int k = 0; k < 6; k++)
                  c[k] = longint'(BASIS_HALVES[f][k]) * (64'sd1 <<< 31);
               for (int s = 0; s < d; s++)
                  for (int k = 0; k < 5 - s; k++)
                     c[k] = c[k+1] * (k + 1);
               acc = c[5-d];
               for (int k = 4 - d; k >= 0; k--)
                  acc = scale_t(acc, t) + c[k];
               neg = acc < 0;
               m = cap(neg ? longint'(-acc) : acc);
               n = int'(SCALE_POW[f]) - d;
               for (; n > 0; n--)
                  m = cap((m >> 16) * h + (((m & 64'hFFFF) * h) >> 16));
               for (; n < 0; n++) begin
                  if (m / h >= (MAG_LIMIT >> 16)) m = MAG_LIMIT;
                  else m = cap(((m / h) << 16) + (((m % h) << 16) / h));
               end
               m = (m + (64'd1 << 15)) >> 16;
               if (neg) begin
                  if (m > 64'h8000_0000) m = 64'h8000_0000;
                  row.val[f] = 32'(-m);
               end else begin
                  if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
                  row.val[f] = m[31:0];
               end
            end
            row.end_knot  = (d == 3);
            row.end_table = last;
            pending.push_back(row);
         end
      endfunction

      function void check_row(logic [191:0] data, logic [2:0] user, logic tlast);
         basis_row_type row;
         if (pending.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
            return;
         end
         row = pending.pop_front();
         if (user[1:0] !== row.order) begin
            $error("deriv_order expected %0d actual %0d", row.order, user[1:0]);
            errors++;
         end
         for (int f = 0; f < 6; f++)
            if (data[32*f +: 32] !== row.val[f]) begin
               $error("val_h%0d%0d expected %0d actual %0d", f % 2, f / 2,
                      $signed(row.val[f]), $signed(data[32*f +: 32]));
               errors++;
            end
         if (tlast !== row.end_knot) begin
            $error("end_of_knot expected %0d actual %0d", row.end_knot, tlast);
            errors++;
         end
         if (user[2] !== row.end_table) begin
            $error("end_of_table expected %0d actual %0d", row.end_table, user[2]);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [23:0]             req_tdata;   // knot_param
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [NUM_FN*VAL_W-1:0] rsp_tdata;   // val_h00, val_h10, val_h01, val_h11, val_h02, val_h12
   logic [2:0]              rsp_tuser;   // deriv_order, end_of_table
   logic                    rsp_tlast;
   logic                    csr_wr_en;
   logic [H_W-1:0]          csr_wr_data;

   basis_scoreboard knots = new();
   logic [23:0]     interval_len;
   int              send_idle_pct;
   int              recv_stall_pct;
   longint          cycles;

   quintic_hermite_basis_derivatives dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         knots.check_row(rsp_tdata, rsp_tuser, rsp_tlast);

   task automatic send_knot(logic [16:0] t, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, t};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      knots.note_knot(t, last, interval_len);
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (knots.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_interval(logic [23:0] h);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      interval_len = h;
   endtask

   task automatic random_knots(int count);
      logic [16:0] t;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0:       t = 17'($urandom_range(131071));
            1:       t = ($urandom_range(1)) ? 17'd0 : 17'd65536;
            default: t = 17'($urandom_range(65536));
         endcase
         send_knot(t, ($urandom_range(7) == 0));
      end
   endtask

   initial begin
      logic [23:0] lengths [0:7];
      int idle_mode [0:7];
      lengths   = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd0, 24'd32768,
                    24'd0, 24'd0, 24'd0};
      idle_mode = '{0, 1, 2, 3, 0, 1, 2, 3};
      for (int i = 5; i < 8; i++) lengths[i] = 24'($urandom_range(24'hFFFFFF, 1));
      cycles = 0;
      interval_len = H_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed knots at reset interval length
      send_knot(17'd0, 1'b0);
      send_knot(17'd65536, 1'b1);
      send_knot(17'd1, 1'b0);
      send_knot(17'd65535, 1'b0);
      send_knot(17'd32768, 1'b1);
      send_knot(17'd65537, 1'b0);
      send_knot(17'd131071, 1'b1);
      send_knot(17'h15555, 1'b0);
      send_knot(17'h0AAAA, 1'b0);

      for (int p = 0; p < 8; p++) begin
         write_interval(lengths[p]);
         case (idle_mode[p])
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         if (p == 1 || p == 2 || p == 3) begin
            send_knot(17'd0, 1'b0);
            send_knot(17'd65536, 1'b0);
            send_knot(17'd131071, 1'b1);
         end
         random_knots(60);
      end
      drain();
      if (knots.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
